// ===== rtl/keypad_code_lock_defines.svh =====
// Assertion macros for the keypad code lock.
`ifndef KEYPAD_CODE_LOCK_DEFINES_SVH
`define KEYPAD_CODE_LOCK_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define KCL_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define KCL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/kcl_pkg.sv =====
// Shared types and constants for the keypad code lock.
package kcl_pkg;

  localparam int CODE_LEN = 5;
  localparam int IDX_W    = (CODE_LEN > 1) ? $clog2(CODE_LEN) : 1;

  localparam logic [IDX_W-1:0] LAST_CNT    = IDX_W'(CODE_LEN - 1);
  localparam logic [2:0]       DONE_DIGITS = 3'(CODE_LEN);

  localparam logic [7:0] KEY_CHANGE = 8'd0;
  localparam logic [7:0] KEY_UNLOCK = 8'd1;

  typedef enum logic [3:0] {
    ST_ENTER_OLD  = 4'd0,
    ST_ENTER_CODE = 4'd1,
    ST_INVALID    = 4'd2,
    ST_DIGIT      = 4'd3,
    ST_DENIED     = 4'd4,
    ST_GRANTED    = 4'd5,
    ST_WRONG_OLD  = 4'd6,
    ST_ENTER_NEW  = 4'd7,
    ST_CHANGED    = 4'd8,
    ST_CLOSED     = 4'd9
  } status_t;

  typedef enum logic [4:0] {
    MODE_MENU   = 5'b00001,
    MODE_UNLOCK = 5'b00010,
    MODE_OPEN   = 5'b00100,
    MODE_OLD    = 5'b01000,
    MODE_NEW    = 5'b10000
  } mode_t;

  typedef struct packed {
    status_t    status;
    logic       lock_open;
    logic [2:0] digits;
  } result_t;

endpackage

// ===== rtl/kcl_in_stage.sv =====
// Input register for keypad keys.
module kcl_in_stage (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] key_code,
  input  logic       take,
  output logic       key_valid,
  output logic [7:0] key
);

  assign in_ready = !key_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_valid <= 1'b0;
    end else if (in_ready) begin
      key_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      key <= key_code;
    end
  end

endmodule

// ===== rtl/kcl_core.sv =====
// Lock state machine, code storage and per-key result logic.
`include "keypad_code_lock_defines.svh"

module kcl_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              key_valid,
  input  logic [7:0]        key,
  input  logic              res_free,
  output logic              take,
  output kcl_pkg::result_t  res
);

  kcl_pkg::mode_t mode, mode_next;
  logic [kcl_pkg::IDX_W-1:0] cnt, cnt_next, cnt_inc;
  logic match, match_next, match_hit;
  logic open_flag, open_next;
  logic last, entry_we, stored_we;
  logic [7:0] stored [kcl_pkg::CODE_LEN];
  logic [7:0] entry  [kcl_pkg::CODE_LEN];
  logic [7:0] stored_fill [kcl_pkg::CODE_LEN];

  assign take      = key_valid && res_free;
  assign cnt_inc   = cnt + 1'b1;
  assign last      = (cnt == kcl_pkg::LAST_CNT);
  assign match_hit = match && (stored[cnt] == key);

  always_comb begin
    for (int i = 0; i < kcl_pkg::CODE_LEN; i++) begin
      stored_fill[i] = (kcl_pkg::IDX_W'(i) == cnt) ? key : entry[i];
    end
  end

  always_comb begin
    mode_next  = mode;
    cnt_next   = cnt;
    match_next = match;
    open_next  = open_flag;
    entry_we   = 1'b0;
    stored_we  = 1'b0;
    res.status = kcl_pkg::ST_INVALID;
    res.digits = 3'd0;
    unique case (mode)
      kcl_pkg::MODE_UNLOCK: begin
        match_next = match_hit;
        if (!last) begin
          cnt_next   = cnt_inc;
          res.status = kcl_pkg::ST_DIGIT;
          res.digits = 3'(cnt_inc);
        end else begin
          cnt_next   = '0;
          res.digits = kcl_pkg::DONE_DIGITS;
          if (match_hit) begin
            open_next  = 1'b1;
            mode_next  = kcl_pkg::MODE_OPEN;
            res.status = kcl_pkg::ST_GRANTED;
          end else begin
            mode_next  = kcl_pkg::MODE_MENU;
            res.status = kcl_pkg::ST_DENIED;
          end
        end
      end
      kcl_pkg::MODE_OLD: begin
        match_next = match_hit;
        if (!last) begin
          cnt_next   = cnt_inc;
          res.status = kcl_pkg::ST_DIGIT;
          res.digits = 3'(cnt_inc);
        end else begin
          cnt_next   = '0;
          res.digits = kcl_pkg::DONE_DIGITS;
          if (match_hit) begin
            mode_next  = kcl_pkg::MODE_NEW;
            res.status = kcl_pkg::ST_ENTER_NEW;
          end else begin
            mode_next  = kcl_pkg::MODE_MENU;
            res.status = kcl_pkg::ST_WRONG_OLD;
          end
        end
      end
      kcl_pkg::MODE_OPEN: begin
        open_next  = 1'b0;
        mode_next  = kcl_pkg::MODE_MENU;
        cnt_next   = '0;
        res.status = kcl_pkg::ST_CLOSED;
      end
      kcl_pkg::MODE_NEW: begin
        entry_we = 1'b1;
        if (last) begin
          stored_we  = 1'b1;
          mode_next  = kcl_pkg::MODE_MENU;
          cnt_next   = '0;
          res.status = kcl_pkg::ST_CHANGED;
          res.digits = kcl_pkg::DONE_DIGITS;
        end else begin
          cnt_next   = cnt_inc;
          res.status = kcl_pkg::ST_DIGIT;
          res.digits = 3'(cnt_inc);
        end
      end
      default: begin
        cnt_next   = '0;
        match_next = 1'b1;
        if (key == kcl_pkg::KEY_CHANGE) begin
          mode_next  = kcl_pkg::MODE_OLD;
          res.status = kcl_pkg::ST_ENTER_OLD;
        end else if (key == kcl_pkg::KEY_UNLOCK) begin
          mode_next  = kcl_pkg::MODE_UNLOCK;
          res.status = kcl_pkg::ST_ENTER_CODE;
        end else begin
          mode_next  = kcl_pkg::MODE_MENU;
          res.status = kcl_pkg::ST_INVALID;
        end
      end
    endcase
    res.lock_open = open_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= kcl_pkg::MODE_MENU;
      cnt       <= '0;
      match     <= 1'b1;
      open_flag <= 1'b0;
    end else if (take) begin
      mode      <= mode_next;
      cnt       <= cnt_next;
      match     <= match_next;
      open_flag <= open_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < kcl_pkg::CODE_LEN; i++) begin
        stored[i] <= 8'd0;
      end
    end else if (take && stored_we) begin
      for (int i = 0; i < kcl_pkg::CODE_LEN; i++) begin
        stored[i] <= stored_fill[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && entry_we) begin
      entry[cnt] <= key;
    end
  end

  `KCL_ASSERT_IMPL(a_open_mode, 1'b1, open_flag == (mode == kcl_pkg::MODE_OPEN), "open flag out of step with mode")
  `KCL_ASSERT_IMPL(a_cnt_range, 1'b1, cnt <= kcl_pkg::LAST_CNT, "entry count past code length")
  `KCL_ASSERT_IMPL(a_menu_cnt, mode == kcl_pkg::MODE_MENU, cnt == '0, "entry count not cleared in menu")
  `KCL_ASSERT_NEXT(a_grant_open, take && res.status == kcl_pkg::ST_GRANTED, mode == kcl_pkg::MODE_OPEN, "grant did not open lock")

endmodule

// ===== rtl/kcl_out_stage.sv =====
// Result register for lock status transfers.
module kcl_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              res_valid,
  input  kcl_pkg::result_t  res,
  output logic              res_free,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [3:0]        status,
  output logic              lock_open,
  output logic [2:0]        digits_entered
);

  kcl_pkg::result_t held;

  assign res_free       = !out_valid || out_ready;
  assign status         = held.status;
  assign lock_open      = held.lock_open;
  assign digits_entered = held.digits;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_free) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_free) begin
      held <= res;
    end
  end

endmodule

// ===== rtl/keypad_code_lock.sv =====
// Keypad code lock top level: input register, lock logic, result register.
// Path: input register, lock logic, result register; a low out_ready stalls the path.
// Throughput: one key per cycle when not stalled; one pass of the lock logic per key.
// Reset (rst, synchronous): both stages empty, lock in menu and closed,
// stored code all zeros; no clearing pass.
module keypad_code_lock (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] key_code,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [3:0] status,
  output logic       lock_open,
  output logic [2:0] digits_entered
);

  logic             key_valid;
  logic [7:0]       key;
  logic             take;
  logic             res_free;
  kcl_pkg::result_t res;

  kcl_in_stage u_in (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .key_code  (key_code),
    .take      (take),
    .key_valid (key_valid),
    .key       (key)
  );

  kcl_core u_core (
    .clk       (clk),
    .rst       (rst),
    .key_valid (key_valid),
    .key       (key),
    .res_free  (res_free),
    .take      (take),
    .res       (res)
  );

  kcl_out_stage u_out (
    .clk            (clk),
    .rst            (rst),
    .res_valid      (key_valid),
    .res            (res),
    .res_free       (res_free),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .lock_open      (lock_open),
    .digits_entered (digits_entered)
  );

endmodule

// ===== sim/lock_status_checker.sv =====
`timescale 1ns / 1ps
// Checker for the keypad code lock: predicts the result of each key and compares transfers.
module lock_status_checker
  import kcl_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] key_code,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [3:0] status,
  input  logic       lock_open,
  input  logic [2:0] digits_entered,
  output int         errors,
  output int         pending
);

  mode_t      lock_mode;
  logic [7:0] saved_code [CODE_LEN];
  logic [7:0] new_code [CODE_LEN];
  int         taken;
  logic       code_ok;
  logic       is_open;
  result_t    status_due_q [$];

  initial errors = 0;
  initial pending = 0;

  task automatic report_error(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    errors++;
  endtask

  function automatic result_t lock_next_result(input logic [7:0] key);
    result_t r;
    r.status = ST_INVALID;
    r.lock_open = 1'b0;
    r.digits = 3'd0;
    case (lock_mode)
      MODE_UNLOCK, MODE_OLD: begin
        if (saved_code[taken] != key) code_ok = 1'b0;
        taken++;
        if (taken < CODE_LEN) begin
          r.status = ST_DIGIT;
          r.digits = 3'(taken);
        end else begin
          r.digits = DONE_DIGITS;
          taken = 0;
          if (!code_ok) begin
            r.status = (lock_mode == MODE_UNLOCK) ? ST_DENIED : ST_WRONG_OLD;
            lock_mode = MODE_MENU;
          end else if (lock_mode == MODE_UNLOCK) begin
            r.status = ST_GRANTED;
            is_open = 1'b1;
            lock_mode = MODE_OPEN;
          end else begin
            r.status = ST_ENTER_NEW;
            lock_mode = MODE_NEW;
          end
        end
      end
      MODE_OPEN: begin
        is_open = 1'b0;
        lock_mode = MODE_MENU;
        taken = 0;
        r.status = ST_CLOSED;
      end
      MODE_NEW: begin
        new_code[taken] = key;
        taken++;
        if (taken >= CODE_LEN) begin
          saved_code = new_code;
          lock_mode = MODE_MENU;
          taken = 0;
          r.status = ST_CHANGED;
          r.digits = DONE_DIGITS;
        end else begin
          r.status = ST_DIGIT;
          r.digits = 3'(taken);
        end
      end
      default: begin
        lock_mode = MODE_MENU;
        taken = 0;
        code_ok = 1'b1;
        if (key == KEY_CHANGE) begin
          lock_mode = MODE_OLD;
          r.status = ST_ENTER_OLD;
        end else if (key == KEY_UNLOCK) begin
          lock_mode = MODE_UNLOCK;
          r.status = ST_ENTER_CODE;
        end
      end
    endcase
    r.lock_open = is_open;
    return r;
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      lock_mode = MODE_MENU;
      foreach (saved_code[i]) saved_code[i] = '0;
      foreach (new_code[i]) new_code[i] = '0;
      taken = 0;
      code_ok = 1'b1;
      is_open = 1'b0;
      status_due_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (status_due_q.size() == 0) begin
          report_error($sformatf("result transfer with nothing expected, status %0d", status));
        end else begin
          want = status_due_q.pop_front();
          if (status !== want.status)
            report_error($sformatf("status %0d, expected %0d (%s)",
                                   status, want.status, want.status.name()));
          if (lock_open !== want.lock_open)
            report_error($sformatf("lock_open %b, expected %b", lock_open, want.lock_open));
          if (digits_entered !== want.digits)
            report_error($sformatf("digits_entered %0d, expected %0d",
                                   digits_entered, want.digits));
        end
      end
      if (in_valid && in_ready) status_due_q.push_back(lock_next_result(key_code));
    end
    pending <= status_due_q.size();
  end

endmodule

// ===== sim/tb_keypad_code_lock.sv =====
`timescale 1ns / 1ps
// Testbench top for the keypad code lock: clock, reset, key stimulus and verdict.
module tb_keypad_code_lock;
  import kcl_pkg::*;

  localparam int LIMIT       = 300000;
  localparam int RANDOM_KEYS = 1500;

  typedef logic [7:0] code_t [CODE_LEN];

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] key_code = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [3:0] status;
  logic       lock_open;
  logic [2:0] digits_entered;
  int         errors;
  int         pending;
  int         cycles = 0;
  int         sent = 0;
  logic       src_burst = 1'b0;
  logic       snk_burst = 1'b0;
  code_t      known_code;

  keypad_code_lock i_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .key_code       (key_code),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .lock_open      (lock_open),
    .digits_entered (digits_entered)
  );

  lock_status_checker i_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .key_code       (key_code),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .lock_open      (lock_open),
    .digits_entered (digits_entered),
    .errors         (errors),
    .pending        (pending)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic int draw_gap(input logic burst);
    return burst ? 0 : $urandom_range(0, 7);
  endfunction

  function automatic logic [7:0] pick_key();
    case ($urandom_range(0, 3))
      0: return 8'($urandom_range(0, 9));
      1: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic code_t random_code();
    code_t r;
    foreach (r[i]) r[i] = pick_key();
    return r;
  endfunction

  function automatic code_t corrupt(input code_t c);
    code_t r;
    int    p;
    r = c;
    p = $urandom_range(0, CODE_LEN - 1);
    r[p] = r[p] ^ 8'($urandom_range(1, 255));
    return r;
  endfunction

  task automatic send_key(input logic [7:0] k);
    int gap;
    if ($urandom_range(0, 31) == 0) src_burst = ~src_burst;
    gap = draw_gap(src_burst);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    key_code <= k;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  task automatic send_code(input code_t c);
    foreach (c[i]) send_key(c[i]);
  endtask

  initial begin
    int gap;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if ($urandom_range(0, 31) == 0) snk_burst = ~snk_burst;
      gap = draw_gap(snk_burst);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin
    code_t next_code;
    int    pick;
    int    base;
    int    noise;
    foreach (known_code[i]) known_code[i] = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // invalid menu choices, unlock with the reset code, close with a change key
    send_key(8'd2);
    send_key(8'hFF);
    send_key(KEY_UNLOCK);
    send_code(known_code);
    send_key(KEY_CHANGE);
    // change to an alternating extreme code, then fail the old-code check
    send_key(KEY_CHANGE);
    send_code(known_code);
    foreach (next_code[i]) next_code[i] = (i % 2 == 0) ? 8'hFF : 8'h00;
    send_code(next_code);
    known_code = next_code;
    send_key(KEY_CHANGE);
    send_code(corrupt(known_code));

    base = sent;
    while (sent - base < RANDOM_KEYS) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        send_key(KEY_UNLOCK);
        send_code(known_code);
        send_key(pick_key());
      end else if (pick < 50) begin
        send_key(KEY_UNLOCK);
        send_code(corrupt(known_code));
      end else if (pick < 55) begin
        send_key(KEY_UNLOCK);
        send_code(random_code());
      end else if (pick < 75) begin
        send_key(KEY_CHANGE);
        send_code(known_code);
        next_code = random_code();
        send_code(next_code);
        known_code = next_code;
      end else if (pick < 85) begin
        send_key(KEY_CHANGE);
        send_code(corrupt(known_code));
      end else begin
        noise = $urandom_range(1, 3);
        repeat (noise) send_key(8'($urandom_range(2, 255)));
      end
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
